### rtl/double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double ended queue
// Clocked concurrent assertion wrappers on clock, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Checked outside reset only
`define DEQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every edge, reset included
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Sizes, codes, word types and helpers shared by the double ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

   // Sizing
   localparam int CAPACITY   = 16;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int SUM_BITS   = IDX_BITS + 1;

   // Operation codes; codes above peek act as peek
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK       = 3'd4
   } deq_op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } deq_status_type;

   // Request word
   typedef struct packed {
      deq_op_type         op;
      logic signed [31:0] push_value;
   } deq_req_type;

   // Result word
   typedef struct packed {
      logic signed [31:0] popped_value;
      deq_status_type     status;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic               is_empty;
      logic               is_full;
      logic [4:0]         entry_count;
   } deq_rsp_type;

   // Sign-extend (or cut) a stored value to the 32-bit result width
   function automatic logic signed [31:0] to_out32(input logic [VALUE_BITS-1:0] v);
      logic signed [VALUE_BITS-1:0] s;
      s = signed'(v);
      return 32'(s);
   endfunction

   // Minimum stored value as seen on the result ports
   localparam logic signed [31:0] MIN_VALUE = to_out32({1'b1, {(VALUE_BITS-1){1'b0}}});

   // Ring position of the back entry; front itself when empty
   function automatic logic [IDX_BITS-1:0] back_pos(input logic [IDX_BITS-1:0] front,
                                                    input logic [CNT_BITS-1:0] occ);
      logic [SUM_BITS-1:0] s;
      s = SUM_BITS'(front) + SUM_BITS'(occ) - SUM_BITS'(1);
      if (occ == '0) begin
         s = SUM_BITS'(front);
      end else if (s >= SUM_BITS'(CAPACITY)) begin
         s = s - SUM_BITS'(CAPACITY);
      end
      return IDX_BITS'(s);
   endfunction

endpackage

`default_nettype wire

### rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports, registered read (old data).
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]                 rd_data_a,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]                 rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and both registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

### rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque in a ring RAM: push/pop at either end, peek, with end values.
// ----------------------------------------------------------------------------
//
//   channel   ports                      direction  handshake
//   request   start, busy, req_data      in         start && !busy
//   result    rsp_strobe, rsp_data       out        one-cycle strobe
//
// An operation runs through the RAM read of the old ends (pop value),
// the update with the read of the new ends, and the result register.
// The next word is taken in the cycle its predecessor's result strobes.
// Synchronous reset clears the front pointer and count; RAM contents are
// never cleared, as only live entries are ever read.
// The receiver cannot stall; a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_assert.svh"

module double_ended_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire deq_pkg::deq_req_type req_data,
   output logic                      rsp_strobe,
   output deq_pkg::deq_rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH
   } state_type;

   localparam int IB = deq_pkg::IDX_BITS;
   localparam int CB = deq_pkg::CNT_BITS;
   localparam int VB = deq_pkg::VALUE_BITS;

   state_type                state_ff, state_in;
   logic [IB-1:0]            front_ff, front_in;
   logic [CB-1:0]            occ_ff, occ_in;
   deq_pkg::deq_req_type     req_ff, req_in;
   logic signed [31:0]       popped_ff, popped_in;
   deq_pkg::deq_status_type  status_ff, status_in;
   logic                     fwd_a_ff, fwd_a_in;
   logic                     fwd_b_ff, fwd_b_in;
   logic [VB-1:0]            fwd_data_ff;
   deq_pkg::deq_rsp_type     rsp_ff, rsp_in;
   logic                     strobe_ff, strobe_in;

   logic                     ram_wr_en;
   logic [IB-1:0]            ram_wr_addr;
   logic [VB-1:0]            ram_wr_data;
   logic [IB-1:0]            ram_rd_addr_a, ram_rd_addr_b;
   logic [VB-1:0]            ram_rd_data_a, ram_rd_data_b;

   logic [IB-1:0]            front_dec, front_inc;
   logic                     is_full_now, is_empty_now;
   logic [VB-1:0]            front_word, back_word;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // Ring neighbors of the front pointer
   assign front_dec = (front_ff == '0) ? IB'(deq_pkg::CAPACITY - 1) : front_ff - IB'(1);
   assign front_inc = (front_ff == IB'(deq_pkg::CAPACITY - 1)) ? '0 : front_ff + IB'(1);

   assign is_full_now  = (occ_ff == CB'(deq_pkg::CAPACITY));
   assign is_empty_now = (occ_ff == '0);

   // Operation decode and pointer update
   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      occ_in      = occ_ff;
      req_in      = req_ff;
      popped_in   = popped_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = front_ff;
      ram_wr_data = VB'(req_ff.push_value);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            popped_in = deq_pkg::MIN_VALUE;
            status_in = deq_pkg::ST_OK;
            unique case (req_ff.op)
               deq_pkg::OP_PUSH_FRONT: begin
                  if (is_full_now) begin
                     status_in = deq_pkg::ST_FULL;
                  end else begin
                     front_in    = front_dec;
                     occ_in      = occ_ff + CB'(1);
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = front_dec;
                  end
               end
               deq_pkg::OP_PUSH_BACK: begin
                  if (is_full_now) begin
                     status_in = deq_pkg::ST_FULL;
                  end else begin
                     occ_in      = occ_ff + CB'(1);
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = deq_pkg::back_pos(front_ff, occ_ff + CB'(1));
                  end
               end
               deq_pkg::OP_POP_FRONT: begin
                  if (is_empty_now) begin
                     status_in = deq_pkg::ST_EMPTY;
                  end else begin
                     popped_in = deq_pkg::to_out32(ram_rd_data_a);
                     front_in  = front_inc;
                     occ_in    = occ_ff - CB'(1);
                  end
               end
               deq_pkg::OP_POP_BACK: begin
                  if (is_empty_now) begin
                     status_in = deq_pkg::ST_EMPTY;
                  end else begin
                     popped_in = deq_pkg::to_out32(ram_rd_data_b);
                     occ_in    = occ_ff - CB'(1);
                  end
               end
               default: begin
                  // peek and unused codes: no change
               end
            endcase
            state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Read the ends as they stand after any update; forward a same-cycle write
   assign ram_rd_addr_a = front_in;
   assign ram_rd_addr_b = deq_pkg::back_pos(front_in, occ_in);
   assign fwd_a_in      = ram_wr_en && (ram_wr_addr == ram_rd_addr_a);
   assign fwd_b_in      = ram_wr_en && (ram_wr_addr == ram_rd_addr_b);

   assign front_word = fwd_a_ff ? fwd_data_ff : ram_rd_data_a;
   assign back_word  = fwd_b_ff ? fwd_data_ff : ram_rd_data_b;

   // Result word
   always_comb begin
      rsp_in              = rsp_ff;
      strobe_in           = (state_ff == S_FETCH);
      if (state_ff == S_FETCH) begin
         rsp_in.popped_value = popped_ff;
         rsp_in.status       = status_ff;
         rsp_in.front_value  = is_empty_now ? deq_pkg::MIN_VALUE
                                            : deq_pkg::to_out32(front_word);
         rsp_in.back_value   = is_empty_now ? deq_pkg::MIN_VALUE
                                            : deq_pkg::to_out32(back_word);
         rsp_in.is_empty     = is_empty_now;
         rsp_in.is_full      = is_full_now;
         rsp_in.entry_count  = 5'(occ_ff);
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         front_ff  <= '0;
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         occ_ff    <= occ_in;
         strobe_ff <= strobe_in;
      end
      req_ff      <= req_in;
      popped_ff   <= popped_in;
      status_ff   <= status_in;
      fwd_a_ff    <= fwd_a_in;
      fwd_b_ff    <= fwd_b_in;
      fwd_data_ff <= ram_wr_data;
      rsp_ff      <= rsp_in;
   end

   // Ring store
   deq_ram #(
      .WIDTH (VB),
      .DEPTH (deq_pkg::CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   // Checks
   `DEQ_ASSERT(a_occ_bound, occ_ff <= CB'(deq_pkg::CAPACITY), "count above capacity")
   `DEQ_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
   `DEQ_ASSERT(a_strobe_fetch, rsp_strobe |-> $past(state_ff == S_FETCH), "strobe out of sequence")
   `DEQ_ASSERT(a_empty_status, (rsp_strobe && rsp_data.status == deq_pkg::ST_EMPTY) |-> rsp_data.is_empty, "empty pop on nonempty deque")
   `DEQ_ASSERT(a_write_exec, ram_wr_en |-> (state_ff == S_EXEC), "RAM write outside update")
   `DEQ_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_strobe, "strobe after reset")

endmodule

`default_nettype wire
